// ===== rtl/core/kvsp_pkg.sv =====
package kvsp_pkg;

  localparam int NUM_NAMES = 13;
  localparam int NAME_MAX  = 13;   // longest table entry, in bytes

  localparam logic [3:0]  UNKNOWN_FIELD  = 4'd12;
  localparam logic [15:0] MAX_LENGTH_RST = 16'd10000;

  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_COLON     = 8'h3a;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Field names, table order gives the field index.
  localparam logic [NAME_MAX*8-1:0] NAME_STR [NUM_NAMES] = '{
    "version", "ip-address", "ip-name", "tcp-port", "database-name",
    "cost", "cost-unit", "free", "maintainer", "description",
    "keyword-list", "source", "unknown"
  };

  localparam logic [15:0] NAME_LEN [NUM_NAMES] = '{
    16'd7, 16'd10, 16'd7, 16'd8, 16'd13,
    16'd4, 16'd9, 16'd4, 16'd10, 16'd11,
    16'd12, 16'd6, 16'd7
  };

  typedef enum logic [3:0] {
    ST_BEGIN        = 4'd0,
    ST_BEFORE_TAG   = 4'd1,
    ST_NAME         = 4'd2,
    ST_BEFORE_VALUE = 4'd3,
    ST_PLAIN        = 4'd4,
    ST_BRACKET      = 4'd5,
    ST_QUOTED       = 4'd6,
    ST_ESCAPE       = 4'd7,
    ST_DONE         = 4'd8
  } parse_state_e;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } name_wr_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic [3:0] field_index;
    logic       value_start;
    logic       commit;
    logic       finished;
  } result_t;

  // Byte k of table entry i, counted from the first character.
  function automatic logic [7:0] name_byte(input int i, input int k);
    logic [NAME_MAX*8-1:0] s;
    s = NAME_STR[i] << (8 * (NAME_MAX - int'(NAME_LEN[i])));
    return s[8*(NAME_MAX-1-k) +: 8];
  endfunction

endpackage

// ===== rtl/core/kvsp_char_if.sv =====
interface kvsp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

// ===== rtl/core/kvsp_res_if.sv =====
interface kvsp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       byte_valid;
  logic [3:0] field_index;
  logic       value_start;
  logic       commit;
  logic       finished;

  modport source (output valid, output value_byte, output byte_valid,
                  output field_index, output value_start, output commit,
                  output finished, input ready);
  modport sink   (input valid, input value_byte, input byte_valid,
                  input field_index, input value_start, input commit,
                  input finished, output ready);
endinterface

// ===== rtl/core/kvsp_cfg_if.sv =====
interface kvsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/keyword_value_source_parser_top.sv =====
// Channel | Dir | Payload                                       | Beat taken when
// in_i    | in  | char_in[7:0]                                  | valid & ready
// cfg_i   | in  | data[15:0] -> max_length                      | valid & ready (ready tied)
// res_o   | out | value_byte, byte_valid, field_index,          | valid & ready
//         |     | value_start, commit, finished                 |
//
// One byte per clock sustained while res_o is not stalled; a taken byte reaches
// res_o through the input register, then the result register.
// The rate is set by the single pass from the input register through the
// state update and the parallel name compare into the result register.
// Reset (rst_ni, async, active low) clears the parser state and loads
// max_length with 10000; the name store holds no reset and needs no sweep.
// A stall on res_o holds the result register; the input register takes one more
// beat only if it is empty, then in_i.ready drops until the result is taken.
module keyword_value_source_parser_top import kvsp_pkg::*; #(
  parameter int NAME_CHARS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kvsp_char_if.sink    in_i,
  kvsp_cfg_if.sink     cfg_i,
  kvsp_res_if.source   res_o
);

  logic       adv;
  logic       item_valid;
  logic [7:0] item_char;
  logic       res_valid;
  result_t    res;

  // Configuration writes land at once; touch the register only while idle (unenforced).
  assign cfg_i.ready = 1'b1;

  // Hold the incoming byte until the engine can advance it.
  kvsp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .char_i  (in_i.char_in),
    .ready_o (in_i.ready),
    .adv_i   (adv),
    .valid_o (item_valid),
    .char_o  (item_char)
  );

  // Parse state, name match and result register.
  kvsp_engine #(
    .NAME_CHARS (NAME_CHARS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .in_valid_i  (item_valid),
    .char_i      (item_char),
    .adv_o       (adv),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_valid),
    .res_o       (res)
  );

  // Drive the result beat.
  assign res_o.valid       = res_valid;
  assign res_o.value_byte  = res.value_byte;
  assign res_o.byte_valid  = res.byte_valid;
  assign res_o.field_index = res.field_index;
  assign res_o.value_start = res.value_start;
  assign res_o.commit      = res.commit;
  assign res_o.finished    = res.finished;

endmodule

// ===== rtl/core/kvsp_in_stage.sv =====
module kvsp_in_stage import kvsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] char_i,
  output logic       ready_o,
  input  logic       adv_i,
  output logic       valid_o,
  output logic [7:0] char_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;

  // Take a new beat when empty or when the held byte moves on.
  assign ready_o = !valid_q || adv_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      char_q <= char_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;

endmodule

// ===== rtl/core/kvsp_name_store.sv =====
module kvsp_name_store import kvsp_pkg::*; #(
  parameter int NAME_CHARS = 16
) (
  input  logic        clk_i,
  input  name_wr_t    wr_i,
  input  logic [15:0] count_i,
  output logic [3:0]  field_idx_o
);

  localparam int IDX_W = $clog2(NAME_CHARS);

  logic [7:0] store_q [NAME_CHARS];
  logic       hit;

  // Hold only the first NAME_CHARS bytes of a name.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (count_i < 16'(NAME_CHARS))) begin
      store_q[count_i[IDX_W-1:0]] <= wr_i.data;
    end
  end

  // Compare against every table entry at once; lowest index wins.
  always_comb begin
    field_idx_o = UNKNOWN_FIELD;
    for (int i = NUM_NAMES - 1; i >= 0; i--) begin
      hit = (count_i == NAME_LEN[i]);
      for (int k = 0; k < NAME_MAX; k++) begin
        if (k < int'(NAME_LEN[i])) begin
          hit = hit && (store_q[IDX_W'(k)] == name_byte(i, k));
        end
      end
      if (hit) begin
        field_idx_o = 4'(i);
      end
    end
  end

endmodule

// ===== rtl/core/kvsp_engine.sv =====
module kvsp_engine import kvsp_pkg::*; #(
  parameter int NAME_CHARS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic [7:0]  char_i,
  output logic        adv_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output result_t     res_o
);

  parse_state_e state_q, state_d;
  logic [15:0]  count_q, count_d;
  logic [3:0]   field_q, field_d;
  logic [15:0]  max_len_q;
  logic         out_valid_q, out_valid_d;
  result_t      res_q, res_d;
  name_wr_t     name_wr;
  logic [3:0]   match_idx;
  logic         white;
  logic         keep_ok;

  kvsp_name_store #(
    .NAME_CHARS (NAME_CHARS)
  ) u_name_store (
    .clk_i       (clk_i),
    .wr_i        (name_wr),
    .count_i     (count_q),
    .field_idx_o (match_idx)
  );

  assign adv_o   = in_valid_i && (!out_valid_q || out_ready_i);
  assign white   = (char_i <= CH_SPACE);
  assign keep_ok = (count_q < max_len_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    field_d = field_q;
    res_d   = '0;
    name_wr = '{en: 1'b0, data: char_i};
    case (state_q)
      ST_BEGIN: begin
        if (char_i == CH_LPAREN) begin
          state_d = ST_BEFORE_TAG;
        end
      end
      ST_BEFORE_TAG: begin
        if (char_i == CH_RPAREN) begin
          state_d = ST_DONE;
        end else if (char_i == CH_COLON) begin
          count_d = '0;
          state_d = ST_NAME;
        end
      end
      ST_NAME: begin
        if (white) begin
          field_d = match_idx;
          state_d = ST_BEFORE_VALUE;
        end else if (keep_ok) begin
          name_wr.en = adv_o;
          count_d    = count_q + 16'd1;
        end
      end
      ST_BEFORE_VALUE: begin
        if (char_i == CH_RPAREN) begin
          state_d = ST_DONE;
        end else if (!white) begin
          res_d.value_start = 1'b1;
          if (char_i == CH_QUOTE) begin
            count_d = '0;
            state_d = ST_QUOTED;
          end else begin
            count_d          = 16'd1;
            res_d.value_byte = char_i;
            res_d.byte_valid = 1'b1;
            state_d = (char_i == CH_LPAREN) ? ST_BRACKET : ST_PLAIN;
          end
        end
      end
      ST_PLAIN: begin
        if (white) begin
          res_d.commit = 1'b1;
          state_d      = ST_BEFORE_TAG;
        end else if (keep_ok) begin
          count_d          = count_q + 16'd1;
          res_d.value_byte = char_i;
          res_d.byte_valid = 1'b1;
        end
      end
      ST_BRACKET: begin
        if (char_i == CH_RPAREN) begin
          res_d.commit = 1'b1;
          state_d      = ST_BEFORE_TAG;
        end else if (keep_ok) begin
          count_d          = count_q + 16'd1;
          res_d.value_byte = char_i;
          res_d.byte_valid = 1'b1;
        end
      end
      ST_QUOTED: begin
        if (char_i == CH_QUOTE) begin
          res_d.commit = 1'b1;
          state_d      = ST_BEFORE_TAG;
        end else if (char_i == CH_BACKSLASH) begin
          state_d = ST_ESCAPE;
        end else if (keep_ok) begin
          count_d          = count_q + 16'd1;
          res_d.value_byte = char_i;
          res_d.byte_valid = 1'b1;
        end
      end
      ST_ESCAPE: begin
        if (keep_ok) begin
          count_d          = count_q + 16'd1;
          res_d.value_byte = char_i;
          res_d.byte_valid = 1'b1;
        end
        state_d = ST_QUOTED;
      end
      default: begin
        state_d = ST_DONE;
      end
    endcase
    res_d.field_index = field_d;
    res_d.finished    = (state_d == ST_DONE);
  end

  // Result register: load on advance, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BEGIN;
      count_q     <= '0;
      field_q     <= '0;
      max_len_q   <= MAX_LENGTH_RST;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      if (adv_o) begin
        state_q <= state_d;
        count_q <= count_d;
        field_q <= field_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (state_q == ST_DONE))
    else $error("parser left the done state");

  a_start_xor_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.value_start && res_q.commit))
    else $error("value start and commit on one beat");

  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_q <= UNKNOWN_FIELD)
    else $error("field number out of range");

  a_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(res_q)))
    else $error("stalled result changed");

  a_finished_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_o && res_d.finished) |=> (state_q == ST_DONE))
    else $error("finished flag without done state");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import kvsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAME_CHARS = 16;

  // Shapes a value can take after its name.
  typedef enum int {
    FORM_PLAIN,
    FORM_BRACKET,
    FORM_QUOTED
  } value_form_e;

  // The field table, in the order that gives the field index.
  string field_names [NUM_NAMES] = '{
    "version", "ip-address", "ip-name", "tcp-port", "database-name",
    "cost", "cost-unit", "free", "maintainer", "description",
    "keyword-list", "source", "unknown"
  };

  logic clk = 1'b0;
  logic rst_n;

  kvsp_char_if in_if ();
  kvsp_cfg_if  cfg_if ();
  kvsp_res_if  res_if ();

  keyword_value_source_parser_top #(
    .NAME_CHARS (NAME_CHARS)
  ) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // 20 ns period, high half first.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Parser state as the testbench sees it, advanced once per accepted beat.
  parse_state_e p_state;
  logic [7:0]   p_name [NAME_CHARS];
  int           p_count;
  logic [3:0]   p_field;
  int           p_max_len;

  // Result beats still owed by the block, oldest first.
  result_t      due_results [$];

  int           fails;
  int           sent_beats;
  bit           tx_eager;     // sender offers back to back
  bit           rx_eager;     // receiver takes every beat at once
  int           rx_hold;      // one long hold-off requested of the receiver

  // Match the buffered name against the table; anything else is unknown.
  function automatic logic [3:0] lookup_field();
    string s;
    bit    same;
    if (p_count > NAME_CHARS) return UNKNOWN_FIELD;
    for (int i = 0; i < NUM_NAMES; i++) begin
      s = field_names[i];
      if (s.len() == p_count) begin
        same = 1'b1;
        for (int k = 0; k < p_count; k++)
          if (s[k] != p_name[k]) same = 1'b0;
        if (same) return 4'(i);
      end
    end
    return UNKNOWN_FIELD;
  endfunction

  // Count a value byte against the length limit; false means drop it.
  function automatic bit take_byte();
    if (p_count < p_max_len) begin
      p_count++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the result beat that one input byte causes, and advance the state.
  function automatic result_t parse_char(input logic [7:0] c);
    result_t r;
    r = '0;
    case (p_state)
      ST_BEGIN: begin
        if (c == CH_LPAREN) p_state = ST_BEFORE_TAG;
      end
      ST_BEFORE_TAG: begin
        if (c == CH_RPAREN) begin
          p_state = ST_DONE;
        end else if (c == CH_COLON) begin
          p_count = 0;
          p_state = ST_NAME;
        end
      end
      ST_NAME: begin
        if (c <= CH_SPACE) begin
          p_field = lookup_field();
          p_state = ST_BEFORE_VALUE;
        end else if (p_count < p_max_len) begin
          if (p_count < NAME_CHARS) p_name[p_count] = c;
          p_count++;
        end
      end
      ST_BEFORE_VALUE: begin
        if (c == CH_RPAREN) begin
          p_state = ST_DONE;
        end else if (c > CH_SPACE) begin
          r.value_start = 1'b1;
          if (c == CH_QUOTE) begin
            p_count = 0;
            p_state = ST_QUOTED;
          end else begin
            // first byte is kept whatever the limit
            p_count = 1;
            r.value_byte = c;
            r.byte_valid = 1'b1;
            p_state = (c == CH_LPAREN) ? ST_BRACKET : ST_PLAIN;
          end
        end
      end
      ST_PLAIN: begin
        if (c <= CH_SPACE) begin
          r.commit = 1'b1;
          p_state = ST_BEFORE_TAG;
        end else if (take_byte()) begin
          r.value_byte = c;
          r.byte_valid = 1'b1;
        end
      end
      ST_BRACKET: begin
        if (c == CH_RPAREN) begin
          r.commit = 1'b1;
          p_state = ST_BEFORE_TAG;
        end else if (take_byte()) begin
          r.value_byte = c;
          r.byte_valid = 1'b1;
        end
      end
      ST_QUOTED: begin
        if (c == CH_QUOTE) begin
          r.commit = 1'b1;
          p_state = ST_BEFORE_TAG;
        end else if (c == CH_BACKSLASH) begin
          p_state = ST_ESCAPE;
        end else if (take_byte()) begin
          r.value_byte = c;
          r.byte_valid = 1'b1;
        end
      end
      ST_ESCAPE: begin
        if (take_byte()) begin
          r.value_byte = c;
          r.byte_valid = 1'b1;
        end
        p_state = ST_QUOTED;
      end
      default: p_state = ST_DONE;
    endcase
    r.field_index = p_field;
    r.finished    = (p_state == ST_DONE);
    return r;
  endfunction

  // Offer one byte after a random gap, hold it until the block takes the beat,
  // then record what it must produce. Valid is left high for a following beat.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.char_in <= c;
    do @(posedge clk); while (!in_if.ready);
    due_results.push_back(parse_char(c));
    sent_beats++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop valid and wait until every owed result beat has been taken.
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Only ever written with the block idle.
  task automatic write_max_length(input logic [15:0] v);
    wait_drained();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    p_max_len = int'(v);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // One well-formed ':name value' field with random content; starts and ends
  // between fields.
  task automatic send_random_field();
    int          pick;
    int          len;
    value_form_e form;
    logic [7:0]  b;
    pick = $urandom_range(0, 9);
    send_char(CH_COLON);
    if (pick < 7) begin
      send_text(field_names[$urandom_range(0, NUM_NAMES - 1)]);
    end else if (pick == 7) begin
      repeat ($urandom_range(1, 20)) send_char(8'($urandom_range(33, 255)));
    end else if (pick == 8) begin
      // a table name with a tail, at times past the name store
      send_text(field_names[$urandom_range(0, NUM_NAMES - 1)]);
      repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(33, 255)));
    end
    repeat ($urandom_range(1, 2)) send_char(8'($urandom_range(0, 32)));
    len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    form = value_form_e'($urandom_range(0, 2));
    case (form)
      FORM_PLAIN: begin
        // a close as the first byte would end the text for good
        do b = 8'($urandom_range(33, 255));
        while (b == CH_QUOTE || b == CH_LPAREN || b == CH_RPAREN);
        send_char(b);
        repeat (len) send_char(8'($urandom_range(33, 255)));
        send_char(8'($urandom_range(0, 32)));
      end
      FORM_BRACKET: begin
        send_char(CH_LPAREN);
        repeat (len) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_RPAREN);
          send_char(b);
        end
        send_char(CH_RPAREN);
      end
      default: begin
        send_char(CH_QUOTE);
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_QUOTE || b == CH_BACKSLASH || $urandom_range(0, 7) == 0)
            send_char(CH_BACKSLASH);
          send_char(b);
        end
        send_char(CH_QUOTE);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Junk before the opening bracket (a close and a colon among it) is ignored,
  // as is text between fields once the bracket is open.
  task automatic test_preamble();
    send_text("x:)(  ab\t");
  endtask

  // Every table name, every value form, escapes, and the awkward names.
  task automatic test_every_field();
    send_text(":version 1.2 :ip-address \"10.0.0.1\" :ip-name (host name) :tcp-port 210 ");
    send_text(":database-name \"a\\\"b\\\\c\\n\" :cost 0 :cost-unit x)y :free yes ");
    send_text(":maintainer \"\" :description () :keyword-list \"k l\" :source s ");
    // unknown by table, near miss, empty, exactly the store size, too long
    send_text(":unknown u :costs z : v :abcdefghijklmnop q :keyword-list-extra w ");
    // extreme byte values inside a bracket, and a plain value ended by a zero byte
    send_text(":free ");
    send_char(CH_LPAREN);
    send_char(8'h00);
    send_char(8'hff);
    send_char(CH_RPAREN);
    send_text(":cost ");
    send_char(8'hff);
    send_char(8'h21);
    send_char(8'h00);
  endtask

  // Walk the length limit through its extremes and a cut that still matches.
  task automatic test_length_limit();
    write_max_length(16'd1);
    send_text(":tcp-port 210 :ip-name (abc) :free \"xy\\z\" ");
    write_max_length(16'd0);
    send_text(":version abc :ip-name \"q\" :free (r) ");
    // "cost-unit" cut to four bytes reads as "cost"
    write_max_length(16'd4);
    send_text(":cost-unit 12345 :cost 9 :maintainer \"abcdef\" ");
    write_max_length(16'hffff);
    send_text(":abcdefghijklmnopq r :description \"a fairly long quoted value\" ");
    write_max_length(MAX_LENGTH_RST);
  endtask

  // Hold the receiver off for a long stretch while bytes keep coming, so the
  // block fills and stalls its input; then pause until everything is back.
  task automatic test_stall_fill();
    rx_hold  = 150;
    tx_eager = 1'b1;
    repeat (6) send_random_field();
    tx_eager = 1'b0;
    wait_drained();
  endtask

  // Mostly well-formed fields with random content; some filler between
  // fields, some broken fields, and the odd change of limit.
  task automatic test_random_text();
    int         first;
    logic [7:0] b;
    first = sent_beats;
    while (sent_beats - first < 500) begin
      if ($urandom_range(0, 7) == 0) tx_eager = !tx_eager;
      if ($urandom_range(0, 7) == 0) rx_eager = !rx_eager;
      if ($urandom_range(0, 24) == 0) begin
        case ($urandom_range(0, 4))
          0:       write_max_length(16'd1);
          1:       write_max_length(16'hffff);
          2:       write_max_length(MAX_LENGTH_RST);
          3:       write_max_length(16'($urandom_range(1, 24)));
          default: write_max_length(16'($urandom_range(1, 65535)));
        endcase
      end
      if ($urandom_range(0, 11) == 0) begin
        // broken field: a colon and raw bytes, then close whatever is open
        send_char(CH_COLON);
        repeat ($urandom_range(1, 8)) begin
          b = 8'($urandom_range(0, 255));
          if ((p_state == ST_BEFORE_TAG || p_state == ST_BEFORE_VALUE) && b == CH_RPAREN)
            b = CH_COLON;
          send_char(b);
        end
        while (p_state != ST_BEFORE_TAG && p_state != ST_DONE) begin
          case (p_state)
            ST_NAME, ST_PLAIN: send_char(CH_SPACE);
            ST_BEFORE_VALUE:   send_char("a");
            ST_BRACKET:        send_char(CH_RPAREN);
            ST_QUOTED:         send_char(CH_QUOTE);
            ST_ESCAPE:         send_char("e");
            default:           send_char(CH_LPAREN);
          endcase
        end
      end else begin
        send_random_field();
      end
      if ($urandom_range(0, 3) == 0) begin
        // filler between fields: anything but a colon or a close
        repeat ($urandom_range(1, 4)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_COLON || b == CH_RPAREN);
          send_char(b);
        end
      end
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;
  endtask

  // Close where a value is awaited: no commit, and everything after is
  // ignored with finished held high.
  task automatic test_close_and_after();
    send_text(":source ");
    send_char(CH_RPAREN);
    repeat (20) send_char(8'($urandom_range(0, 255)));
    send_text("(:version 1 )");
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: draw a stall per beat, or take a requested long hold-off.
  initial begin : result_sink
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_eager ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  // Compare every result beat taken with the oldest one owed.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("result beat taken with nothing expected");
        fails++;
      end else begin
        want = due_results.pop_front();
        check_field("value_byte",  want.value_byte,  res_if.value_byte);
        check_field("byte_valid",  8'(want.byte_valid),  8'(res_if.byte_valid));
        check_field("field_index", 8'(want.field_index), 8'(res_if.field_index));
        check_field("value_start", 8'(want.value_start), 8'(res_if.value_start));
        check_field("commit",      8'(want.commit),      8'(res_if.commit));
        check_field("finished",    8'(want.finished),    8'(res_if.finished));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_if.valid   = 1'b0;
    in_if.char_in = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    rst_n         = 1'b0;
    fails         = 0;
    sent_beats    = 0;
    tx_eager      = 1'b0;
    rx_eager      = 1'b0;
    rx_hold       = 0;
    // Predicted state after reset.
    p_state   = ST_BEGIN;
    p_count   = 0;
    p_field   = '0;
    p_max_len = int'(MAX_LENGTH_RST);
    foreach (p_name[i]) p_name[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_preamble();
    test_every_field();
    test_length_limit();
    test_stall_fill();
    test_random_text();
    test_close_and_after();

    // Let the two-stage pipe settle, in case a stray beat follows.
    repeat (4) @(posedge clk);
    if (fails == 0 && due_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Give up well past the slowest correct run.
  initial begin
    #10ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
